>>> hdl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Request and response items, controller states, the command and status
// groups between controller and datapath, and width helpers.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEAP_BLOCKS_DEF     = 1024;
  localparam int RESERVED_BLOCKS_DEF = 1;

  localparam int CNT_W   = 11;
  localparam int START_W = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;

  // Block map word: eight blocks per word of the busy map memory.
  localparam int BMAP_W  = 8;
  localparam int BMAP_SH = 3;

  localparam logic [CFG_W-1:0] HEAP_RESET = 11'd1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] RSP_OK     = 2'd0;
  localparam logic [STAT_W-1:0] RSP_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] RSP_NOTSEG = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [CNT_W-1:0]   block_count;
    logic [START_W-1:0] start_block;
  } ffba_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] granted_block;
  } ffba_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_DONE
  } ffba_state_t;

  typedef struct packed {
    logic              clear_step;
    logic              latch;
    logic              scan_init;
    logic              scan_step;
    logic              load_alloc;
    logic              load_free;
    logic              walk_write;
    logic              set_result;
    logic [STAT_W-1:0] result_code;
  } ffba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic count_zero;
    logic start_oob;
    logic scan_hit;
    logic scan_end;
    logic seg_zero;
    logic walk_last;
  } ffba_stat_t;

  // Width of a block index that can also hold the heap size and the
  // configured limit.
  function automatic int idx_width(input int heap_blocks);
    int aw;
    aw = $clog2(heap_blocks);
    return (aw + 1 > CNT_W) ? aw + 1 : CNT_W;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl: allocator controller
// Sequences the clearing pass, the first-fit scan, the segment lookup and the
// read-modify-write walk over the busy map.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire ffba_pkg::ffba_stat_t stat,
  output logic                     busy,
  output logic                     done,
  output ffba_pkg::ffba_cmd_t      cmd
);

  ffba_pkg::ffba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.result_code = ffba_pkg::RSP_OK;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ffba_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ffba_pkg::ST_DECIDE;
        end
      end
      ffba_pkg::ST_DECIDE: begin
        if (stat.is_free) begin
          if (stat.start_oob) begin
            cmd.set_result  = 1'b1;
            cmd.result_code = ffba_pkg::RSP_NOTSEG;
            state_next      = ffba_pkg::ST_DONE;
          end else begin
            state_next = ffba_pkg::ST_FREE_CHK;
          end
        end else if (stat.count_zero) begin
          cmd.set_result  = 1'b1;
          cmd.result_code = ffba_pkg::RSP_NOFIT;
          state_next      = ffba_pkg::ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ffba_pkg::ST_SCAN;
        end
      end
      ffba_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.load_alloc = 1'b1;
          state_next     = ffba_pkg::ST_WALK_RD;
        end else if (stat.scan_end) begin
          cmd.set_result  = 1'b1;
          cmd.result_code = ffba_pkg::RSP_NOFIT;
          state_next      = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_FREE_CHK: begin
        if (stat.seg_zero) begin
          cmd.set_result  = 1'b1;
          cmd.result_code = ffba_pkg::RSP_NOTSEG;
          state_next      = ffba_pkg::ST_DONE;
        end else begin
          cmd.load_free = 1'b1;
          state_next    = ffba_pkg::ST_WALK_RD;
        end
      end
      ffba_pkg::ST_WALK_RD: begin
        state_next = ffba_pkg::ST_WALK_WR;
      end
      ffba_pkg::ST_WALK_WR: begin
        cmd.walk_write = 1'b1;
        if (stat.walk_last) begin
          cmd.set_result  = 1'b1;
          cmd.result_code = ffba_pkg::RSP_OK;
          state_next      = ffba_pkg::ST_DONE;
        end else begin
          state_next = ffba_pkg::ST_WALK_RD;
        end
      end
      ffba_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = ffba_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffba_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ffba_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dpath: allocator datapath
// Busy map memory of eight-block words, segment length memory, the run
// counter of the first-fit scan and the range walker that sets or clears
// busy bits one word per read-modify-write.
// ----------------------------------------------------------------------------
module ffba_dpath #(
  parameter int HEAP_BLOCKS     = ffba_pkg::HEAP_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = ffba_pkg::RESERVED_BLOCKS_DEF,
  localparam int BW = ffba_pkg::idx_width(HEAP_BLOCKS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffba_pkg::ffba_cmd_t  cmd,
  input  wire ffba_pkg::ffba_req_t  req,
  input  wire logic [BW-1:0]        lim,
  output ffba_pkg::ffba_stat_t      stat,
  output ffba_pkg::ffba_rsp_t       rsp
);

  localparam int AW  = $clog2(HEAP_BLOCKS);
  localparam int WB  = ffba_pkg::BMAP_W;
  localparam int SH  = ffba_pkg::BMAP_SH;
  localparam int CW  = ffba_pkg::CNT_W;
  localparam int NW  = (HEAP_BLOCKS + ffba_pkg::BMAP_W - 1) / ffba_pkg::BMAP_W;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;

  ffba_pkg::ffba_req_t req_q;
  ffba_pkg::ffba_rsp_t rsp_q;

  logic [BW-1:0]  clr_idx;
  logic [WAW-1:0] rd_w;
  logic [WAW-1:0] ev_w;
  logic           ev_valid;
  logic [CW-1:0]  run;
  logic [BW-1:0]  seg_start;
  logic [BW-1:0]  cur;
  logic [CW-1:0]  rem;
  logic           set_op;

  // Memory ports.
  logic           bm_we;
  logic [WAW-1:0] bm_waddr;
  logic [WB-1:0]  bm_wdata;
  logic [WAW-1:0] bm_raddr;
  logic [WB-1:0]  bm_rdata;
  logic           sl_we;
  logic [AW-1:0]  sl_waddr;
  logic [CW-1:0]  sl_wdata;
  logic [CW-1:0]  sl_rdata;

  // Scan evaluation.
  logic [CW-1:0]  run_v;
  logic           hit;
  logic [SH-1:0]  hit_j;
  logic [BW-1:0]  blk_idx;
  logic           blk_free;
  logic [BW-1:0]  start_calc;
  logic [BW-1:0]  word_end;

  // Walk evaluation.
  logic [SH-1:0]  off;
  logic [SH:0]    room;
  logic [SH:0]    n;
  logic [SH:0]    jj;
  logic [WB-1:0]  mask;
  logic [WB-1:0]  clr_word;
  logic [BW-1:0]  avail;

  always_comb begin
    run_v = run;
    hit   = 1'b0;
    hit_j = '0;
    for (int j = 0; j < WB; j++) begin
      blk_idx  = BW'({ev_w, SH'(j)});
      blk_free = !bm_rdata[j] && (blk_idx < lim);
      run_v    = blk_free ? run_v + CW'(1) : '0;
      if (!hit && blk_free && (run_v == req_q.block_count)) begin
        hit   = 1'b1;
        hit_j = SH'(j);
      end
    end
  end

  assign start_calc = BW'({ev_w, hit_j}) + BW'(1) - BW'(req_q.block_count);
  assign word_end   = BW'({ev_w, SH'(0)}) + BW'(WB);

  // Blocks handled by this walk step: from the current offset to the end of
  // the word or of the range, whichever comes first.
  assign off  = cur[SH-1:0];
  assign room = (SH+1)'(WB) - {1'b0, off};
  assign n    = (rem < CW'(room)) ? rem[SH:0] : room;

  always_comb begin
    mask = '0;
    for (int j = 0; j < WB; j++) begin
      jj      = (SH+1)'(j);
      mask[j] = (jj >= {1'b0, off}) && ((jj - {1'b0, off}) < n);
    end
  end

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      clr_word[j] = ((BW+SH)'({clr_idx, SH'(j)}) < (BW+SH)'(RESERVED_BLOCKS));
    end
  end

  assign avail = BW'(HEAP_BLOCKS) - seg_start;

  // Memory port selection.
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = cur[SH +: WAW];
    bm_wdata = set_op ? (bm_rdata | mask) : (bm_rdata & ~mask);
    if (cmd.clear_step) begin
      bm_we    = (clr_idx < BW'(NW));
      bm_waddr = clr_idx[WAW-1:0];
      bm_wdata = clr_word;
    end else if (cmd.walk_write) begin
      bm_we = 1'b1;
    end
  end

  assign bm_raddr = cmd.scan_step ? rd_w : cur[SH +: WAW];

  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = seg_start[AW-1:0];
    sl_wdata = '0;
    if (cmd.clear_step) begin
      sl_we    = 1'b1;
      sl_waddr = clr_idx[AW-1:0];
      sl_wdata = (clr_idx == '0) ? CW'(RESERVED_BLOCKS) : '0;
    end else if (cmd.load_alloc) begin
      sl_we    = 1'b1;
      sl_waddr = start_calc[AW-1:0];
      sl_wdata = req_q.block_count;
    end else if (cmd.load_free) begin
      sl_we = 1'b1;
    end
  end

  ffba_ram #(
    .WIDTH (WB),
    .DEPTH (NW)
  ) u_busy_map (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  ffba_ram #(
    .WIDTH (CW),
    .DEPTH (HEAP_BLOCKS)
  ) u_seg_len (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (seg_start[AW-1:0]),
    .rdata (sl_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      ev_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if (cmd.scan_init) begin
        ev_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        ev_valid <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q     <= req;
      seg_start <= BW'(req.start_block);
    end
    if (cmd.scan_init) begin
      rd_w <= '0;
      run  <= '0;
    end else if (cmd.scan_step) begin
      rd_w <= rd_w + WAW'(1);
      ev_w <= rd_w;
      if (ev_valid) begin
        run <= run_v;
      end
    end
    if (cmd.load_alloc) begin
      seg_start <= start_calc;
      cur       <= start_calc;
      rem       <= req_q.block_count;
      set_op    <= 1'b1;
    end else if (cmd.load_free) begin
      cur    <= seg_start;
      rem    <= (BW'(sl_rdata) < avail) ? sl_rdata : avail[CW-1:0];
      set_op <= 1'b0;
    end else if (cmd.walk_write) begin
      cur <= cur + BW'(n);
      rem <= rem - CW'(n);
    end
    if (cmd.set_result) begin
      rsp_q.status <= cmd.result_code;
      rsp_q.granted_block <=
        ((cmd.result_code == ffba_pkg::RSP_OK) && (req_q.kind == ffba_pkg::KIND_ALLOC))
        ? seg_start[ffba_pkg::START_W-1:0] : '0;
    end
  end

  assign stat.clear_last = (clr_idx == BW'(HEAP_BLOCKS - 1));
  assign stat.is_free    = (req_q.kind == ffba_pkg::KIND_FREE);
  assign stat.count_zero = (req_q.block_count == '0);
  assign stat.start_oob  = (seg_start >= BW'(HEAP_BLOCKS));
  assign stat.scan_hit   = ev_valid && hit;
  assign stat.scan_end   = ev_valid && !hit && (word_end >= lim);
  assign stat.seg_zero   = (sl_rdata == '0);
  assign stat.walk_last  = (CW'(n) == rem);

  assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> hdl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit block allocator with coalescing
// Hands out and takes back runs of heap blocks, lowest address first.
// ----------------------------------------------------------------------------
// Usage. A request item is taken at a clock edge where start is high and busy
// is low; req carries the kind (allocate or free), the block count and the
// start block. Exactly one response item follows: done is high for a single
// cycle with rsp holding the status and the granted block. The receiver has
// no way to stall, so it must take the item in that cycle.
// Timing. Requests are handled one at a time. An allocate request reads the
// busy map at one eight-block word per cycle, from the lowest word up to the
// first fit (all words below the heap limit when nothing fits), and then
// walks the map words the new segment touches. A free request walks only
// the map words of the freed segment. The busy map has a single read port;
// every word a walk touches is read once and rewritten in the following
// cycle.
// Reset. After rst a clearing pass writes the segment length memory, and the
// busy map alongside it, from block 0 up to HEAP_BLOCKS - 1. busy stays high
// during the pass. The reserved blocks come out of reset as one live segment at block 0.
// Configuration. cfg_data sets the heap size in blocks and is written whenever
// cfg_valid is high; cfg_ready is always high. Values above HEAP_BLOCKS act as
// HEAP_BLOCKS. Write it only while no request is in flight.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int HEAP_BLOCKS     = ffba_pkg::HEAP_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = ffba_pkg::RESERVED_BLOCKS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire ffba_pkg::ffba_req_t       req,
  output logic                           done,
  output ffba_pkg::ffba_rsp_t            rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ffba_pkg::CFG_W-1:0] cfg_data
);

  localparam int BW = ffba_pkg::idx_width(HEAP_BLOCKS);

  logic [ffba_pkg::CFG_W-1:0] heap_blocks;
  logic [BW-1:0]              lim;
  ffba_pkg::ffba_cmd_t        cmd;
  ffba_pkg::ffba_stat_t       stat;

  // The heap size register is always writable; the controller never looks
  // at it outside a request, so no hold-off is needed.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_blocks <= ffba_pkg::HEAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_blocks <= cfg_data;
    end
  end

  // Allocations never reach past the smaller of the configured size and the
  // physical map; live segments above a lowered limit can still be freed.
  assign lim = (BW'(heap_blocks) > BW'(HEAP_BLOCKS)) ? BW'(HEAP_BLOCKS) : BW'(heap_blocks);

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ffba_dpath #(
    .HEAP_BLOCKS     (HEAP_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .lim  (lim),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire
